// ===== rtl/core/wildcard_glob_matcher_defines.svh =====
// assertion macros for the wildcard glob matcher
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

// same-cycle implication
`define WGM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wgm assertion failed");

// next-cycle implication
`define WGM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wgm assertion failed");

`endif

// ===== rtl/core/wgm_pkg.sv =====
// shared types and constants of the wildcard glob matcher
// no dependencies
package wgm_pkg;

  localparam int unsigned PATTERN_MAX = 32;

  localparam logic [7:0] STAR_BYTE  = 8'd42;
  localparam logic [7:0] QUEST_BYTE = 8'd63;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_NAME   = 2'd2,
    OP_END    = 2'd3
  } wgm_op_e;

  // hand-off from one cell to its right neighbor
  typedef struct packed {
    logic close;
    logic adv;
  } wgm_link_t;

  // broadcast control to all cells
  typedef struct packed {
    logic       rearm;
    logic       step;
    logic [7:0] chr;
  } wgm_ctrl_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } wgm_res_t;

endpackage

// ===== rtl/core/wgm_if.sv =====
// channel interfaces of the wildcard glob matcher
// depends on nothing; valid/ready transfer with payload
interface wgm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] character;

  modport source (output valid, output operation, output character, input ready);
  modport sink (input valid, input operation, input character, output ready);
endinterface

interface wgm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink (input valid, input matched, input pattern_overflow, output ready);
endinterface

// ===== rtl/core/wgm_cell.sv =====
// one pattern position: stored byte and its nfa activity bit
// depends on wgm_pkg
module wgm_cell #(
  parameter logic IsHead = 1'b0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wgm_pkg::wgm_ctrl_t ctrl_i,
  input  logic              wr_i,
  input  logic              valid_i,
  input  logic              at_end_i,
  input  wgm_pkg::wgm_link_t left_i,
  output wgm_pkg::wgm_link_t right_o,
  output logic              hit_o
);

  logic [7:0] byte_q;
  logic       raw_q, raw_d;
  logic       is_star, is_lit_match, act;

  assign is_star      = valid_i && (byte_q == wgm_pkg::STAR_BYTE);
  assign is_lit_match = valid_i && !is_star &&
                        ((byte_q == wgm_pkg::QUEST_BYTE) || (byte_q == ctrl_i.chr));

  // star runs are collapsed on load, so closure needs only the raw bit of the left cell
  assign act           = raw_q | left_i.close;
  assign right_o.close = raw_q & is_star;
  assign right_o.adv   = act & is_lit_match;
  assign hit_o         = act & at_end_i;

  always_comb begin
    raw_d = raw_q;
    if (ctrl_i.rearm) begin
      raw_d = IsHead;
    end else if (ctrl_i.step) begin
      raw_d = (act & is_star) | left_i.adv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q <= IsHead;
    end else begin
      raw_q <= raw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      byte_q <= ctrl_i.chr;
    end
  end

endmodule

// ===== rtl/core/wgm_outbuf.sv =====
// result register with one skid entry
// depends on wgm_pkg and wgm_out_if
module wgm_outbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wgm_pkg::wgm_res_t data_i,
  output logic             full_o,
  wgm_out_if.source        out_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  wgm_pkg::wgm_res_t out_data_q, out_data_d;
  wgm_pkg::wgm_res_t skid_data_q, skid_data_d;
  logic              out_fire;

  assign out_fire = out_valid_q && out_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || out_fire) begin
        out_data_d  = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o                 = skid_valid_q;
  assign out_o.valid            = out_valid_q;
  assign out_o.matched          = out_data_q.matched;
  assign out_o.pattern_overflow = out_data_q.pattern_overflow;

endmodule

// ===== rtl/core/wildcard_glob_matcher.sv =====
// top level of the wildcard glob matcher: control, row of cells, result buffer
// depends on wgm_pkg, wgm_if, wgm_cell, wgm_outbuf and the defines header
//
// usage:
//   in_i carries operation and character. clear empties the pattern, append
//   adds one pattern byte, name feeds one name byte, end of name produces one
//   result on out_o (matched, pattern_overflow). other operations give none.
//   every operation is handled in a row of PatternMax+1 cells, one per
//   pattern position; each cell updates its activity bit from its left
//   neighbor, so one item is accepted per clock while in_i.ready is high.
//   an end-of-name result is registered in the result register, or in the skid entry while an earlier result waits.
//   out_o has a result register plus one skid entry: input keeps flowing while
//   one result waits; in_i.ready drops only when both entries hold results.
//   consecutive stars are stored as one, while the byte count still follows
//   every appended byte for the overflow limit.
//   after reset the pattern is empty, overflow is clear and no result is held.
`include "wildcard_glob_matcher_defines.svh"

module wildcard_glob_matcher #(
  parameter int unsigned PatternMax = wgm_pkg::PATTERN_MAX
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wgm_in_if.sink    in_i,
  wgm_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(PatternMax + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] plen_q, plen_d;
  logic            ovf_q, ovf_d;
  logic            last_star_q, last_star_d;

  logic              in_fire, buf_full, push, wr_any, room, in_star;
  wgm_pkg::wgm_op_e  op;
  wgm_pkg::wgm_ctrl_t ctrl;
  wgm_pkg::wgm_res_t res;

  wgm_pkg::wgm_link_t link [PatternMax+1];
  wgm_pkg::wgm_link_t tail_link;
  logic [PatternMax:0] hits;

  assign in_i.ready = !buf_full;
  assign in_fire    = in_i.valid && in_i.ready;
  assign op         = wgm_pkg::wgm_op_e'(in_i.operation);
  assign room       = cnt_q < CntW'(PatternMax);
  assign in_star    = in_i.character == wgm_pkg::STAR_BYTE;

  always_comb begin
    cnt_d       = cnt_q;
    plen_d      = plen_q;
    ovf_d       = ovf_q;
    last_star_d = last_star_q;
    ctrl.rearm  = 1'b0;
    ctrl.step   = 1'b0;
    ctrl.chr    = in_i.character;
    push        = 1'b0;
    wr_any      = 1'b0;
    if (in_fire) begin
      case (op)
        wgm_pkg::OP_CLEAR: begin
          cnt_d       = '0;
          plen_d      = '0;
          ovf_d       = 1'b0;
          last_star_d = 1'b0;
          ctrl.rearm  = 1'b1;
        end
        wgm_pkg::OP_APPEND: begin
          ctrl.rearm = 1'b1;
          if (room) begin
            cnt_d = cnt_q + CntW'(1);
            if (!(in_star && last_star_q)) begin
              wr_any      = 1'b1;
              plen_d      = plen_q + CntW'(1);
              last_star_d = in_star;
            end
          end else begin
            ovf_d = 1'b1;
          end
        end
        wgm_pkg::OP_NAME: begin
          ctrl.step = 1'b1;
        end
        wgm_pkg::OP_END: begin
          ctrl.rearm = 1'b1;
          push       = 1'b1;
        end
        default: begin
          ctrl.rearm = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      plen_q      <= '0;
      ovf_q       <= 1'b0;
      last_star_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      plen_q      <= plen_d;
      ovf_q       <= ovf_d;
      last_star_q <= last_star_d;
    end
  end

  assign link[0] = '0;

  for (genvar k = 0; k <= PatternMax; k++) begin : g_cell
    wgm_pkg::wgm_link_t right;

    wgm_cell #(
      .IsHead (k == 0)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .wr_i     (wr_any && (plen_q == CntW'(k))),
      .valid_i  (CntW'(k) < plen_q),
      .at_end_i (CntW'(k) == plen_q),
      .left_i   (link[k]),
      .right_o  (right),
      .hit_o    (hits[k])
    );

    if (k < PatternMax) begin : g_link
      assign link[k+1] = right;
    end else begin : g_tail
      assign tail_link = right;
    end
  end

  assign res.matched          = (|hits) && !ovf_q;
  assign res.pattern_overflow = ovf_q;

  wgm_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (res),
    .full_o (buf_full),
    .out_o  (out_o)
  );

  `WGM_ASSERT_NOW(a_len_le_cnt, 1'b1, plen_q <= cnt_q)
  `WGM_ASSERT_NOW(a_tail_quiet, 1'b1, tail_link == '0)
  `WGM_ASSERT_NOW(a_skid_needs_out, buf_full, out_o.valid)
  `WGM_ASSERT_NEXT(a_clear_empties, in_fire && (op == wgm_pkg::OP_CLEAR),
                   (plen_q == '0) && !ovf_q && (cnt_q == '0))

endmodule

// ===== sim/wildcard_glob_matcher_tb.sv =====
// self-checking testbench of the wildcard glob matcher: directed cases, then random
// pattern/name sequences with bursty input and a stalling result side
// depends on wgm_pkg, wgm_if and the wildcard_glob_matcher top level
module wildcard_glob_matcher_tb;
  import wgm_pkg::*;

  localparam int unsigned PMAX = PATTERN_MAX;
  localparam int unsigned ITEM_TARGET = 650;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned TAIL_CYCLES = 16;

  class glob_match_scoreboard;
    logic [7:0] pattern_bytes [PMAX];
    int unsigned pattern_len;
    bit [PMAX:0] active;
    bit dropped;
    wgm_res_t verdicts [$];
    int unsigned mismatches;

    function new();
      foreach (pattern_bytes[i]) pattern_bytes[i] = 8'h00;
      pattern_len = 0;
      dropped = 1'b0;
      mismatches = 0;
      rearm();
    endfunction

    function void rearm();
      active = '0;
      active[0] = 1'b1;
    endfunction

    // stars may match empty, so activity flows through them
    function void close_stars();
      for (int i = 0; i < pattern_len; i++) begin
        if (active[i] && pattern_bytes[i] == STAR_BYTE) active[i + 1] = 1'b1;
      end
    endfunction

    function void consume_byte(logic [7:0] ch);
      bit [PMAX:0] nxt;
      nxt = '0;
      close_stars();
      for (int i = 0; i < pattern_len; i++) begin
        if (active[i]) begin
          if (pattern_bytes[i] == STAR_BYTE) nxt[i] = 1'b1;
          else if (pattern_bytes[i] == QUEST_BYTE || pattern_bytes[i] == ch) nxt[i + 1] = 1'b1;
        end
      end
      active = nxt;
      close_stars();
    endfunction

    function void note_item(wgm_op_e op, logic [7:0] ch);
      wgm_res_t v;
      case (op)
        OP_CLEAR: begin
          pattern_len = 0;
          dropped = 1'b0;
          rearm();
        end
        OP_APPEND: begin
          if (pattern_len < PMAX) begin
            pattern_bytes[pattern_len] = ch;
            pattern_len++;
          end else begin
            dropped = 1'b1;
          end
          rearm();
        end
        OP_NAME: begin
          consume_byte(ch);
        end
        default: begin
          close_stars();
          v.matched = active[pattern_len] && !dropped;
          v.pattern_overflow = dropped;
          verdicts.push_back(v);
          rearm();
        end
      endcase
    endfunction

    function int unsigned outstanding();
      return verdicts.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_verdict(logic matched, logic pattern_overflow);
      wgm_res_t want;
      if (verdicts.size() == 0) begin
        report("result transfer with no end of name pending");
      end else begin
        want = verdicts.pop_front();
        if (matched !== want.matched)
          report($sformatf("matched got %b want %b", matched, want.matched));
        if (pattern_overflow !== want.pattern_overflow)
          report($sformatf("pattern_overflow got %b want %b",
                           pattern_overflow, want.pattern_overflow));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  wgm_in_if  in_if ();
  wgm_out_if out_if ();

  wildcard_glob_matcher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  glob_match_scoreboard sb = new();
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send(wgm_op_e op, logic [7:0] ch);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.character <= ch;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(op, ch);
    items_sent++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  function automatic logic [7:0] pick_literal();
    case ($urandom_range(0, 3))
      0: return 8'h61;
      1: return 8'h62;
      2: return 8'h00;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [7:0] pick_pattern_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return STAR_BYTE;
    if (r < 45) return QUEST_BYTE;
    if (r < 85) return pick_literal();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_name_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return pick_literal();
    if (r < 70) return STAR_BYTE;
    if (r < 75) return QUEST_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic run_directed();
    send(OP_END, 8'h00);
    send(OP_NAME, 8'h00);
    send(OP_END, 8'hFF);
    send(OP_APPEND, STAR_BYTE);
    send(OP_END, 8'h00);
    send(OP_CLEAR, 8'hFF);
    send(OP_APPEND, STAR_BYTE);
    send(OP_APPEND, STAR_BYTE);
    send(OP_APPEND, QUEST_BYTE);
    send(OP_APPEND, 8'h00);
    send(OP_APPEND, 8'hFF);
    send(OP_NAME, STAR_BYTE);
    send(OP_NAME, 8'h00);
    send(OP_NAME, 8'hFF);
    send(OP_END, 8'h00);
    send(OP_NAME, 8'h61);
    send(OP_APPEND, 8'h61);
    send(OP_END, 8'h00);
    send(OP_NAME, QUEST_BYTE);
    send(OP_END, 8'h55);
    send(OP_CLEAR, 8'hAA);
  endtask

  task automatic run_sequence(int unsigned seq);
    logic [7:0] pat [$];
    logic [7:0] name [$];
    int unsigned plen;
    int unsigned names;
    int unsigned idx;
    int unsigned r;
    pat = {};
    r = $urandom_range(0, 99);
    if (seq == 1) plen = PMAX + 1 + $urandom_range(0, 3);
    else if (seq == 2) plen = PMAX;
    else if (r < 80) plen = $urandom_range(0, 8);
    else if (r < 95) plen = $urandom_range(9, PMAX);
    else plen = $urandom_range(PMAX + 1, PMAX + 4);
    send(OP_CLEAR, 8'($urandom_range(0, 255)));
    for (int i = 0; i < plen; i++) begin
      pat.push_back(pick_pattern_byte());
      send(OP_APPEND, pat[i]);
    end
    names = $urandom_range(1, 4);
    for (int n = 0; n < names; n++) begin
      name = {};
      if ($urandom_range(0, 9) < 7) begin
        foreach (pat[i]) begin
          if (pat[i] == STAR_BYTE) begin
            repeat ($urandom_range(0, 3)) name.push_back(pick_name_byte());
          end else if (pat[i] == QUEST_BYTE) begin
            name.push_back(pick_name_byte());
          end else begin
            name.push_back(pat[i]);
          end
        end
        if ($urandom_range(0, 9) < 4) begin
          r = $urandom_range(0, 2);
          idx = (name.size() > 0) ? $urandom_range(0, name.size() - 1) : 0;
          if (r == 0 && name.size() > 0) name[idx] = pick_name_byte();
          else if (r == 1) name.push_back(pick_name_byte());
          else if (name.size() > 0) name.delete(idx);
        end
      end else begin
        repeat ($urandom_range(0, 8)) name.push_back(pick_name_byte());
      end
      foreach (name[i]) begin
        // broken sequence: pattern byte arrives mid-name
        if ($urandom_range(0, 99) < 2) send(OP_APPEND, pick_pattern_byte());
        send(OP_NAME, name[i]);
      end
      if ($urandom_range(0, 9) == 0)
        send(wgm_op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      send(OP_END, 8'($urandom_range(0, 255)));
    end
  endtask

  // result side stalls on a pattern that is picked anew at random from four modes
  initial begin
    int unsigned mode;
    int unsigned cnt;
    mode = 0;
    cnt = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cnt++;
      if (cnt % 97 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= $urandom_range(0, 1);
        2: out_if.ready <= (cnt % 4 == 0);
        default: out_if.ready <= (cnt % 10 >= 8);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_verdict(out_if.matched, out_if.pattern_overflow);
  end

  // watchdog on cycles without any transfer
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("wildcard_glob_matcher verification failed");
    $finish;
  end

  initial begin
    int unsigned seq;
    seq = 0;
    rst_ni = 1'b0;
    in_if.valid     <= 1'b0;
    in_if.operation <= OP_CLEAR;
    in_if.character <= 8'h00;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    while (items_sent < ITEM_TARGET) begin
      run_sequence(seq);
      if (seq % 9 == 4) drain_results();
      seq++;
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("wildcard_glob_matcher verification clean");
    end else begin
      $display("wildcard_glob_matcher verification failed");
    end
    $finish;
  end

endmodule
